// ===== rtl/core/mcab_pkg.sv =====
package mcab_pkg;

  // Field and state widths.
  localparam int SAMPLE_W = 12;
  localparam int MASK_W   = 4;
  localparam int SCAN_W   = 4;
  localparam int CH_W     = 3;
  localparam int AVG_W    = 23;
  localparam int SUM_W    = 24;
  localparam int VAL_W    = SAMPLE_W + 1;
  localparam int CNT_W    = 11;
  localparam int SHIFT_W  = 4;
  localparam int NUM_CH   = 6;

  // Longest window that is honored; longer settings are clamped to it.
  localparam int MAX_WINDOW = 1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_WIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SHIFT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]   SAMPLES_WIN_RESET  = 11'd64;
  localparam logic [SHIFT_W-1:0] RESULT_SHIFT_RESET = 4'd6;

  // Channel numbers on the result side.
  localparam logic [CH_W-1:0] CH_SCAN_FIRST  = 3'd0;
  localparam logic [CH_W-1:0] CH_SCAN_SECOND = 3'd1;
  localparam logic [CH_W-1:0] CH_SCAN_THIRD  = 3'd2;
  localparam logic [CH_W-1:0] CH_INPUT_FOUR  = 3'd3;
  localparam logic [CH_W-1:0] CH_INPUT_FIVE  = 3'd4;
  localparam logic [CH_W-1:0] CH_TEMP        = 3'd5;

  // Scan position codes.
  localparam logic [SCAN_W-1:0] SCAN_POS_FIRST  = 4'd1;
  localparam logic [SCAN_W-1:0] SCAN_POS_SECOND = 4'd2;
  localparam logic [SCAN_W-1:0] SCAN_POS_THIRD  = 4'd0;

  // Decoded channel selection handed from the decoder to the accumulators.
  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
  } chan_sel_t;

endpackage

// ===== rtl/core/mcab_decode.sv =====
module mcab_decode
  import mcab_pkg::*;
(
  input  logic [MASK_W-1:0] ch_mask,
  input  logic [SCAN_W-1:0] scan_next,
  output chan_sel_t         sel
);

  // Lowest mask bit wins; an unknown scan position drops the sample.
  always_comb begin
    sel.hit = 1'b0;
    sel.ch  = CH_SCAN_FIRST;
    priority if (ch_mask[0]) begin
      if (scan_next == SCAN_POS_FIRST) begin
        sel.hit = 1'b1;
        sel.ch  = CH_SCAN_FIRST;
      end else if (scan_next == SCAN_POS_SECOND) begin
        sel.hit = 1'b1;
        sel.ch  = CH_SCAN_SECOND;
      end else if (scan_next == SCAN_POS_THIRD) begin
        sel.hit = 1'b1;
        sel.ch  = CH_SCAN_THIRD;
      end
    end else if (ch_mask[1]) begin
      sel.hit = 1'b1;
      sel.ch  = CH_INPUT_FOUR;
    end else if (ch_mask[2]) begin
      sel.hit = 1'b1;
      sel.ch  = CH_INPUT_FIVE;
    end else if (ch_mask[3]) begin
      sel.hit = 1'b1;
      sel.ch  = CH_TEMP;
    end else begin
      // No mask bit set: the sample is dropped.
      sel.hit = 1'b0;
    end
  end

endmodule

// ===== rtl/core/mcab_accum.sv =====
module mcab_accum
  import mcab_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  chan_sel_t                sel,
  input  logic signed [VAL_W-1:0]  val,
  input  logic [CNT_W-1:0]         win,
  input  logic [SHIFT_W-1:0]       shift,
  output logic                     dump,
  output logic signed [AVG_W-1:0]  average_next
);

  logic signed [SUM_W-1:0] sums [NUM_CH];
  logic [CNT_W-1:0]        counts [NUM_CH];

  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        count_next;
  logic signed [SUM_W-1:0] shifted;

  // Add the new sample to the selected channel and check for end of window.
  always_comb begin
    sum_next   = sums[sel.ch] + SUM_W'(val);
    count_next = counts[sel.ch] + CNT_W'(1);
    dump       = (count_next >= win);
  end

  // Floor shift of the window sum, saturated to the result width.
  always_comb begin
    shifted = sum_next >>> shift;
    if (shifted[SUM_W-1] != shifted[AVG_W-1]) begin
      average_next = shifted[SUM_W-1] ? {1'b1, {(AVG_W-1){1'b0}}}
                                      : {1'b0, {(AVG_W-1){1'b1}}};
    end else begin
      average_next = shifted[AVG_W-1:0];
    end
  end

  // Per-channel sums and counts; a dump clears the channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
    end else if (update) begin
      if (dump) begin
        sums[sel.ch]   <= '0;
        counts[sel.ch] <= '0;
      end else begin
        sums[sel.ch]   <= sum_next;
        counts[sel.ch] <= count_next;
      end
    end
  end

endmodule

// ===== rtl/core/multichannel_adc_block_averager.sv =====
// An accepted input is held in the input register, and its result is then
// loaded from there into the result register. Throughput: one sample per
// cycle while the result is not stalled, set by the accumulate and compare
// on the per-channel sum and count registers between the input and result
// registers; a stalled result holds the pipeline.
// Reset (rst, synchronous, active high) clears all sums and counts, empties
// the pipeline and restores offset 0, window 64 and shift 6.
module multichannel_adc_block_averager
  import mcab_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_W-1:0]     sample,
  input  logic [MASK_W-1:0]       ch_mask,
  input  logic [SCAN_W-1:0]       scan_next,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_W-1:0]         channel,
  output logic signed [AVG_W-1:0] average
);

  logic [SAMPLE_W-1:0] zero_offset;
  logic [CNT_W-1:0]    samples_per_window;
  logic [SHIFT_W-1:0]  result_shift;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [MASK_W-1:0]   s1_mask;
  logic [SCAN_W-1:0]   s1_scan;

  logic                    advance;
  logic                    update;
  logic                    dump;
  chan_sel_t               sel;
  logic signed [VAL_W-1:0] val;
  logic [CNT_W-1:0]        win;
  logic signed [AVG_W-1:0] average_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset        <= '0;
      samples_per_window <= SAMPLES_WIN_RESET;
      result_shift       <= RESULT_SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ZERO_OFFSET:  zero_offset        <= cfg_data;
        REG_SAMPLES_WIN:  samples_per_window <= cfg_data[CNT_W-1:0];
        REG_RESULT_SHIFT: result_shift       <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length, clamped to one through the maximum.
  always_comb begin
    if (samples_per_window == '0) begin
      win = CNT_W'(1);
    end else if (samples_per_window > CNT_W'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = samples_per_window;
    end
  end

  // The working stage moves whenever the result register is free or draining.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= sample;
      s1_mask   <= ch_mask;
      s1_scan   <= scan_next;
    end
  end

  mcab_decode u_decode (
    .ch_mask   (s1_mask),
    .scan_next (s1_scan),
    .sel       (sel)
  );

  assign val    = $signed({1'b0, s1_sample}) - $signed({1'b0, zero_offset});
  assign update = s1_valid && advance && sel.hit;

  mcab_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .update       (update),
    .sel          (sel),
    .val          (val),
    .win          (win),
    .shift        (result_shift),
    .dump         (dump),
    .average_next (average_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= update && dump;
    end
  end

  always_ff @(posedge clk) begin
    if (update && dump) begin
      channel <= sel.ch;
      average <= average_next;
    end
  end

endmodule

// ===== rtl/core/mcab_checker.sv =====
module mcab_checker
  import mcab_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CH_W-1:0]         channel,
  input logic signed [AVG_W-1:0] average
);

  // The result register is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(average))
    else $error("stalled result changed");

  // A result that appears in an empty output register comes from the
  // transaction held in the input register when the result register was loaded.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transaction");

  // Only the six defined channels are reported.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel <= CH_TEMP)
    else $error("channel number out of range");

endmodule

bind multichannel_adc_block_averager mcab_checker u_mcab_checker (.*);
